[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Property checks for simulation; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BWO_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BWO_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BWO_ASSERT(lbl, clk, rst, prop, msg)
`define BWO_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif
`endif

[src/bwo_pkg.sv]
// ----------------------------------------------------------------------------
// bwo_pkg
// Shared constants and types of the band-limited wavetable oscillator.
// ----------------------------------------------------------------------------
package bwo_pkg;

  localparam int TABLE_LENGTH = 1024;
  localparam int BANDS        = 16;
  localparam int SAMPLE_BITS  = 16;
  localparam int WAVES        = 4;
  localparam int FRAC_BITS    = 22;

  localparam int TL_LOG2   = $clog2(TABLE_LENGTH);
  localparam int PHASE_W   = TL_LOG2 + FRAC_BITS;
  localparam int IDX_W     = TL_LOG2;
  localparam int ROW_LEN   = TABLE_LENGTH + 1;
  localparam int ROWS      = WAVES * BANDS;
  localparam int ROW_W     = $clog2(ROWS);
  localparam int MEM_DEPTH = ROWS * ROW_LEN;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int WAVE_W  = 2;
  localparam int BAND_W  = 4;
  localparam int TIDX_W  = 11;
  localparam int FREQ_W  = 24;
  localparam int RATE_W  = 19;
  localparam int LIMIT_W = 16;
  localparam int PHIN_W  = 32;

  // Stream and register port widths.
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 24;

  // Step = frequency * TABLE_LENGTH * 2^FRAC_BITS / 16 / sample_rate.
  localparam int STEP_SHIFT = TL_LOG2 + FRAC_BITS - 4;
  localparam int STEP_NUM_W = FREQ_W + STEP_SHIFT;
  localparam int BAND_NUM_W = LIMIT_W + 4;
  localparam int QUO_W      = (PHASE_W > BAND_NUM_W + 1) ? PHASE_W : BAND_NUM_W + 1;
  localparam int DIV_REM_W  = FREQ_W + 1;
  localparam int DIV_CNT_W  = $clog2(STEP_NUM_W);

  // Result queue.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // Commands carried in tuser.
  localparam logic [CMD_W-1:0] CMD_TICK        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET_PHASE   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE_TABLE = 2'd2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FREQUENCY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BAND_LIMIT  = 2'd3;

  localparam logic [WAVE_W-1:0] WAVE_SINE = 2'd0;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_LOAD,
    DIV_STEP,
    DIV_BAND
  } div_state_t;

  typedef struct packed {
    logic                busy;
    logic [WAVE_W-1:0]   wave_type;
    logic [BAND_W-1:0]   band;
    logic [PHASE_W-1:0]  step;
  } derive_t;

endpackage

[src/bwo_derive.sv]
// ----------------------------------------------------------------------------
// bwo_derive
// Register file plus a shared bit-serial divider that derives step and band.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bwo_derive (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bwo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bwo_pkg::CFG_DATA_W-1:0]   cfg_data,
  output bwo_pkg::derive_t                 status
);
  import bwo_pkg::*;

  localparam logic [DIV_CNT_W-1:0] STEP_LAST = DIV_CNT_W'(STEP_NUM_W - 1);
  localparam logic [DIV_CNT_W-1:0] BAND_LAST = DIV_CNT_W'(BAND_NUM_W - 1);

  logic [WAVE_W-1:0]     wave_type;
  logic [FREQ_W-1:0]     frequency;
  logic [RATE_W-1:0]     sample_rate;
  logic [LIMIT_W-1:0]    band_limit;

  div_state_t            state, state_next;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [STEP_NUM_W-1:0] num_sr;
  logic [DIV_REM_W-1:0]  rem;
  logic [QUO_W-1:0]      quo;
  logic [PHASE_W-1:0]    step;
  logic [BAND_W-1:0]     band;

  logic                  cfg_wr;
  logic                  busy;
  logic [FREQ_W-1:0]     div_by;
  logic [RATE_W-1:0]     rate_eff;
  logic [DIV_REM_W-1:0]  rem_sh;
  logic                  ge;
  logic [DIV_REM_W-1:0]  rem_next;
  logic [QUO_W-1:0]      quo_next;
  logic [BAND_W-1:0]     band_sat;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_type   <= WAVE_W'(2);
      frequency   <= FREQ_W'(7040);
      sample_rate <= RATE_W'(48000);
      band_limit  <= LIMIT_W'(20000);
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_WAVE_TYPE:   wave_type   <= cfg_data[WAVE_W-1:0];
        REG_FREQUENCY:   frequency   <= cfg_data[FREQ_W-1:0];
        REG_SAMPLE_RATE: sample_rate <= cfg_data[RATE_W-1:0];
        REG_BAND_LIMIT:  band_limit  <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero sample rate divides as one.
  assign rate_eff = (sample_rate == '0) ? RATE_W'(1) : sample_rate;

  always_comb begin
    state_next = state;
    unique case (state)
      DIV_LOAD: state_next = DIV_STEP;
      DIV_STEP: if (cnt == STEP_LAST) state_next = DIV_BAND;
      DIV_BAND: if (cnt == BAND_LAST) state_next = DIV_IDLE;
      DIV_IDLE: state_next = DIV_IDLE;
      default:  state_next = DIV_LOAD;
    endcase
    if (cfg_wr) state_next = DIV_LOAD;
  end

  always_comb begin
    busy   = 1'b1;
    div_by = '0;
    unique case (state)
      DIV_IDLE: busy = 1'b0;
      DIV_LOAD: ;
      DIV_STEP: div_by = FREQ_W'(rate_eff);
      DIV_BAND: div_by = frequency;
      default: ;
    endcase
  end

  // One restoring-division step. A zero divisor yields all ones, which
  // saturates the band to the top table as wanted for zero frequency.
  always_comb begin
    rem_sh   = {rem[DIV_REM_W-2:0], num_sr[STEP_NUM_W-1]};
    ge       = rem_sh >= {1'b0, div_by};
    rem_next = ge ? (rem_sh - {1'b0, div_by}) : rem_sh;
    quo_next = {quo[QUO_W-2:0], ge};
    if (quo_next == '0) begin
      band_sat = '0;
    end else if (quo_next > QUO_W'(BANDS)) begin
      band_sat = BAND_W'(BANDS - 1);
    end else begin
      band_sat = BAND_W'(quo_next - QUO_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_LOAD;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == DIV_LOAD || cnt == STEP_LAST ||
          (state == DIV_BAND && cnt == BAND_LAST)) begin
        cnt <= '0;
      end else if (state != DIV_IDLE) begin
        cnt <= cnt + DIV_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      DIV_LOAD: begin
        num_sr <= {frequency, {STEP_SHIFT{1'b0}}};
        rem    <= '0;
        quo    <= '0;
      end
      DIV_STEP: begin
        if (cnt == STEP_LAST) begin
          step   <= quo_next[PHASE_W-1:0];
          num_sr <= {band_limit, {(STEP_NUM_W - LIMIT_W){1'b0}}};
          rem    <= '0;
          quo    <= '0;
        end else begin
          num_sr <= {num_sr[STEP_NUM_W-2:0], 1'b0};
          rem    <= rem_next;
          quo    <= quo_next;
        end
      end
      DIV_BAND: begin
        num_sr <= {num_sr[STEP_NUM_W-2:0], 1'b0};
        rem    <= rem_next;
        quo    <= quo_next;
        if (cnt == BAND_LAST) band <= band_sat;
      end
      default: ;
    endcase
  end

  assign status.busy      = busy;
  assign status.wave_type = wave_type;
  assign status.band      = (wave_type == WAVE_SINE) ? '0 : band;
  assign status.step      = step;

  `BWO_ASSERT(a_done_after_band, clk, rst, $fell(busy) |-> $past(state) == DIV_BAND, "derivation ended outside the band pass")

endmodule

[src/bwo_table_ram.sv]
// ----------------------------------------------------------------------------
// bwo_table_ram
// Band table store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module bwo_table_ram (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [bwo_pkg::ADDR_W-1:0]            wr_addr,
  input  logic signed [bwo_pkg::SAMPLE_BITS-1:0] wr_data,
  input  logic                                  rd_en,
  input  logic [bwo_pkg::ADDR_W-1:0]            rd_addr_a,
  input  logic [bwo_pkg::ADDR_W-1:0]            rd_addr_b,
  output logic signed [bwo_pkg::SAMPLE_BITS-1:0] rd_data_a,
  output logic signed [bwo_pkg::SAMPLE_BITS-1:0] rd_data_b
);
  import bwo_pkg::*;

  logic signed [SAMPLE_BITS-1:0] mem [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

[src/bwo_interp.sv]
// ----------------------------------------------------------------------------
// bwo_interp
// Linear interpolation between two neighboring table entries.
// ----------------------------------------------------------------------------
module bwo_interp (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  input  logic signed [bwo_pkg::SAMPLE_BITS-1:0] a,
  input  logic signed [bwo_pkg::SAMPLE_BITS-1:0] b,
  input  logic [bwo_pkg::FRAC_BITS-1:0]          frac,
  input  logic [bwo_pkg::BAND_W-1:0]             band,
  output logic                                   out_valid,
  output logic [bwo_pkg::SAMPLE_BITS-1:0]        sample,
  output logic [bwo_pkg::BAND_W-1:0]             band_used
);
  import bwo_pkg::*;

  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int ACC_W  = DIFF_W + FRAC_BITS + 1;
  localparam int QUOT_W = ACC_W - FRAC_BITS;

  logic signed [DIFF_W-1:0]      diff;
  logic signed [FRAC_BITS:0]     frac_s;
  logic signed [ACC_W-1:0]       prod;
  logic signed [SAMPLE_BITS-1:0] a1;
  logic [BAND_W-1:0]             band1;
  logic                          v1;

  logic signed [ACC_W-1:0]       acc;
  logic [QUOT_W-1:0]             quot;
  logic                          fix;

  assign diff   = DIFF_W'(b) - DIFF_W'(a);
  assign frac_s = {1'b0, frac};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      prod  <= ACC_W'(diff * frac_s);
      a1    <= a;
      band1 <= band;
    end
  end

  // Quotient by 2^FRAC_BITS rounds toward zero: a negative sum with
  // fraction bits left over moves up by one.
  always_comb begin
    acc  = {{(ACC_W - SAMPLE_BITS - FRAC_BITS){a1[SAMPLE_BITS-1]}}, a1, {FRAC_BITS{1'b0}}}
           + prod;
    fix  = acc[ACC_W-1] && (acc[FRAC_BITS-1:0] != '0);
    quot = acc[ACC_W-1:FRAC_BITS] + QUOT_W'(fix);
  end

  assign out_valid = v1;
  assign sample    = quot[SAMPLE_BITS-1:0];
  assign band_used = band1;

endmodule

[src/bwo_out_fifo.sv]
// ----------------------------------------------------------------------------
// bwo_out_fifo
// Small result queue that decouples the sample pipeline from the receiver.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bwo_out_fifo (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  input  logic [bwo_pkg::OUT_TDATA_W-1:0]   push_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bwo_pkg::OUT_TDATA_W-1:0]   m_tdata
);
  import bwo_pkg::*;

  logic [OUT_TDATA_W-1:0] entries [OUT_DEPTH];
  logic [OUT_PTR_W-1:0]   wr_ptr;
  logic [OUT_PTR_W-1:0]   rd_ptr;
  logic [OUT_CNT_W-1:0]   count;
  logic                   pop;

  assign m_tvalid = (count != '0);
  assign m_tdata  = entries[rd_ptr];
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + OUT_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      count <= count + OUT_CNT_W'(push) - OUT_CNT_W'(pop);
    end
  end

  `BWO_ASSERT_NEVER(a_no_overflow, clk, rst, push && !pop && count == OUT_CNT_W'(OUT_DEPTH), "result queue overflow")

endmodule

[src/bandlimited_wavetable_oscillator_core.sv]
// ----------------------------------------------------------------------------
// bandlimited_wavetable_oscillator_core
// Band-limited wavetable oscillator with linear interpolation, top level.
// ----------------------------------------------------------------------------
// Usage. Input beats arrive on the s_ group; tuser carries the command (tick,
// set phase, write table word) and tdata the operands. A tick produces one
// beat on the m_ group with the interpolated sample and the band table used;
// the other commands produce nothing. Registers (wave type, frequency, sample
// rate, band limit) are written through the always ready cfg_ channel; the user
// must write them only while the oscillator is idle; the block does not check it.
// Pipeline. A tick reads the table into the RAM output registers, then passes
// the interpolator register and the result queue before it shows on m_tvalid;
// ticks may follow in every cycle while s_tready is high, one beat per cycle.
// The stages hold the table read, one multiply and one add with rounding.
// Derivation. After reset and after every register write, a shared bit-serial
// divider derives the phase step and then the band, one quotient bit per
// cycle, and s_tready stays low during that time.
// Reset clears the phase, loads the register defaults and starts the
// derivation; table contents are undefined until written.
// Stalls. Results wait in a four-entry queue; s_tready drops once four ticks
// are outstanding and returns as the receiver takes beats.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bandlimited_wavetable_oscillator_core (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // tdata, from bit 0: phase_value[31:0], table_wave[33:32],
  // table_band[37:34], table_index[48:38], table_value[64:49], zeros.
  input  logic [bwo_pkg::IN_TDATA_W-1:0]     s_tdata,
  // tuser: command[1:0].
  input  logic [bwo_pkg::CMD_W-1:0]          s_tuser,
  // Output stream.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // tdata, from bit 0: sample[15:0], band_used[19:16], zeros.
  output logic [bwo_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // Register writes.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [bwo_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bwo_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import bwo_pkg::*;

  // Unpacked input fields.
  logic [PHIN_W-1:0]             phase_value;
  logic [WAVE_W-1:0]             table_wave;
  logic [BAND_W-1:0]             table_band;
  logic [TIDX_W-1:0]             table_index;
  logic signed [SAMPLE_BITS-1:0] table_value;

  assign phase_value = s_tdata[31:0];
  assign table_wave  = s_tdata[33:32];
  assign table_band  = s_tdata[37:34];
  assign table_index = s_tdata[48:38];
  assign table_value = s_tdata[64:49];

  derive_t dstat;

  logic accept;
  logic tick_acc;
  logic set_acc;
  logic wr_acc;

  // Phase accumulator: integer part indexes the table, the rest interpolates.
  logic [PHASE_W-1:0] phase;

  // Credit for results in flight or waiting in the queue.
  logic [OUT_CNT_W-1:0] credit;
  logic                 pop;

  logic [ROW_W-1:0]  rd_row;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [ROW_W-1:0]  wr_row;
  logic [ADDR_W-1:0] wr_addr;
  logic              wr_ok;

  logic                          rd_valid;
  logic [FRAC_BITS-1:0]          frac_q;
  logic [BAND_W-1:0]             band_q;
  logic signed [SAMPLE_BITS-1:0] rd_data_a;
  logic signed [SAMPLE_BITS-1:0] rd_data_b;

  logic                   smp_valid;
  logic [SAMPLE_BITS-1:0] smp;
  logic [BAND_W-1:0]      smp_band;

  bwo_derive u_derive (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (dstat)
  );

  // Ready comes from registers only, never from the receiver side.
  assign s_tready = !dstat.busy && (credit < OUT_CNT_W'(OUT_DEPTH));
  assign accept   = s_tvalid && s_tready;
  assign tick_acc = accept && (s_tuser == CMD_TICK);
  assign set_acc  = accept && (s_tuser == CMD_SET_PHASE);
  assign wr_acc   = accept && (s_tuser == CMD_WRITE_TABLE) && wr_ok;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= '0;
      credit <= '0;
    end else begin
      if (tick_acc) begin
        phase <= phase + dstat.step;
      end else if (set_acc) begin
        phase <= phase_value[PHASE_W-1:0];
      end
      credit <= credit + OUT_CNT_W'(tick_acc) - OUT_CNT_W'(pop);
    end
  end

  // Each wave and band owns one row of TABLE_LENGTH entries plus a guard
  // entry, so the second tap never crosses into the next row.
  assign rd_row    = ROW_W'(dstat.wave_type) * ROW_W'(BANDS) + ROW_W'(dstat.band);
  assign rd_addr_a = ADDR_W'(rd_row) * ADDR_W'(ROW_LEN)
                     + ADDR_W'(phase[PHASE_W-1:FRAC_BITS]);
  assign rd_addr_b = rd_addr_a + ADDR_W'(1);

  // Writes with a band or an index outside the table are dropped.
  assign wr_ok   = (int'(table_band) < BANDS) && (int'(table_index) <= TABLE_LENGTH);
  assign wr_row  = ROW_W'(table_wave) * ROW_W'(BANDS) + ROW_W'(table_band);
  assign wr_addr = ADDR_W'(wr_row) * ADDR_W'(ROW_LEN) + ADDR_W'(table_index);

  bwo_table_ram u_ram (
    .clk       (clk),
    .wr_en     (wr_acc),
    .wr_addr   (wr_addr),
    .wr_data   (table_value),
    .rd_en     (tick_acc),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // Side data that travels alongside the table read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= tick_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_acc) begin
      frac_q <= phase[FRAC_BITS-1:0];
      band_q <= dstat.band;
    end
  end

  bwo_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .a         (rd_data_a),
    .b         (rd_data_b),
    .frac      (frac_q),
    .band      (band_q),
    .out_valid (smp_valid),
    .sample    (smp),
    .band_used (smp_band)
  );

  bwo_out_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (smp_valid),
    .push_data ({{(OUT_TDATA_W - SAMPLE_BITS - BAND_W){1'b0}}, smp_band, smp}),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  `BWO_ASSERT(a_ready_not_busy, clk, rst, s_tready |-> !dstat.busy, "input taken while step and band are being derived")
  `BWO_ASSERT(a_tick_result, clk, rst, tick_acc |-> ##2 smp_valid, "tick did not reach the result queue")
  `BWO_ASSERT_NEVER(a_credit_range, clk, rst, credit > OUT_CNT_W'(OUT_DEPTH), "result credit out of range")

endmodule
